// ===== rtl/core/plsm_pkg.sv =====
// Package for the projected-light sharpness marker.
// Holds shared types, register indexes, mark codes and reset values.
// No dependencies.
package plsm_pkg;

   localparam int MAX_ROW_WIDTH_DEF = 1024;
   localparam int PIX_W = 8;
   localparam int NORM_W = 16;
   localparam int Q_BITS = 15;
   localparam int ENTRY_W = NORM_W + 1;
   localparam int ROW_WIDTH_W = 11;
   localparam int THRESH_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   localparam logic signed [PIX_W:0] LIT_MIN = 9'sd10;
   localparam logic [NORM_W-1:0] ONE_Q15 = 16'h8000;

   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 11'd640;
   localparam logic [THRESH_W-1:0] THRESH_RST = 16'd13074;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARP_THRESH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ_EN = 2'd2;

   localparam logic [1:0] MARK_NONE = 2'd0;
   localparam logic [1:0] MARK_VERT = 2'd1;
   localparam logic [1:0] MARK_HORIZ = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_EVAL,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [PIX_W-1:0] dividend;
      logic [PIX_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic [Q_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/plsm_divider.sv =====
// Radix-2 restoring divider producing floor(a * 2^15 / b) for a < b.
// One quotient bit per cycle. Depends on plsm_pkg.
module plsm_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  plsm_pkg::div_req_type div_req,
   output plsm_pkg::div_rsp_type div_rsp
);
   import plsm_pkg::*;

   localparam int CNT_W = $clog2(Q_BITS + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PIX_W-1:0]  rem_ff, rem_in;
   logic [PIX_W-1:0]  den_ff, den_in;
   logic [Q_BITS-1:0] quo_ff, quo_in;
   logic [PIX_W:0]    shifted;
   logic [PIX_W:0]    diff;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(Q_BITS);
         rem_in = div_req.dividend;
         den_in = div_req.divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff[PIX_W-1:0];
            quo_in = {quo_ff[Q_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[PIX_W-1:0];
            quo_in = {quo_ff[Q_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/plsm_line_mem.sv =====
// Line buffer holding {lit, norm} of the previous row, one entry per column.
// Synchronous memory with one write port and one registered read port.
// Depends on plsm_pkg.
module plsm_line_mem #(
   parameter int DEPTH = plsm_pkg::MAX_ROW_WIDTH_DEF,
   parameter int AW = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [plsm_pkg::ENTRY_W-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [plsm_pkg::ENTRY_W-1:0] wr_data
);
   import plsm_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/projected_light_sharpness_marker_top.sv =====
// Top level of the projected-light sharpness marker.
// Uses plsm_pkg, plsm_divider and plsm_line_mem.
//
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   req_tdata scene, white, black; req_tuser start
// rsp      out        rsp_tvalid/rsp_tready   rsp_tdata norm, lit, vert, horiz, mark
// csr      in         csr_valid/csr_ready     csr_index, csr_data
//
// Each word passes through the bit-serial divider (15 steps), evaluation and emit before the next is accepted.
// The line buffer is read at acceptance and written once the result is loaded.
// A new word is accepted while the previous result waits in the output register.
// Reset is synchronous; the line buffer is not cleared and needs no clearing pass.
module projected_light_sharpness_marker_top #(
   parameter int MAX_ROW_WIDTH = plsm_pkg::MAX_ROW_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // scene_pixel[7:0], white_pixel[15:8], black_pixel[23:16]
   input  logic [plsm_pkg::REQ_DATA_W-1:0] req_tdata,
   // frame_start[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // norm_value[15:0], lit[16], vert_diff[32:17], horiz_diff[48:33], sharp_mark[50:49]
   output logic [plsm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [plsm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [plsm_pkg::CSR_DATA_W-1:0] csr_data
);
   import plsm_pkg::*;

   localparam int AW = $clog2(MAX_ROW_WIDTH);
   localparam int EW = $clog2(MAX_ROW_WIDTH + 1);
   localparam int CMP_W = (EW > ROW_WIDTH_W) ? EW : ROW_WIDTH_W;
   localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_ROW_WIDTH);

   state_type state_ff, state_in;

   logic [ROW_WIDTH_W-1:0] row_width_ff;
   logic [THRESH_W-1:0]    thresh_ff;
   logic                   horiz_en_ff;

   logic [AW-1:0]          col_ff, col_in;
   logic                   first_row_ff, first_row_in;
   logic [ENTRY_W-1:0]     left_ff;

   logic signed [PIX_W:0]  d_ff, c_ff, d_in, c_in;
   logic                   lit_ff, lit_in;
   logic [NORM_W-1:0]      norm_ff, norm_in;
   logic [NORM_W-1:0]      vdiff_ff, vdiff_in, hdiff_ff, hdiff_in;

   logic                   rsp_valid_ff;
   logic [NORM_W-1:0]      out_norm_ff, out_vdiff_ff, out_hdiff_ff;
   logic                   out_lit_ff;
   logic [1:0]             out_mark_ff, mark_in;

   logic                   req_acc;
   logic                   eval_load, emit_load;
   logic [AW-1:0]          rd_addr;
   logic [ENTRY_W-1:0]     up_entry;
   logic [CMP_W-1:0]       eff_width, row_width_ext, col_next;

   div_req_type            div_req;
   div_rsp_type            div_rsp;

   plsm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   plsm_line_mem #(
      .DEPTH (MAX_ROW_WIDTH),
      .AW    (AW)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (req_acc),
      .rd_addr (rd_addr),
      .rd_data (up_entry),
      .wr_en   (emit_load),
      .wr_addr (col_ff),
      .wr_data ({lit_ff, norm_ff})
   );

   // Control sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      eval_load = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!div_rsp.busy) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            eval_load = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               emit_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_acc = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // Acceptance: differences, frame restart and divider start.
   always_comb begin
      d_in = $signed({1'b0, req_tdata[15:8]}) - $signed({1'b0, req_tdata[23:16]});
      c_in = $signed({1'b0, req_tdata[7:0]}) - $signed({1'b0, req_tdata[23:16]});
      rd_addr = req_tuser ? '0 : col_ff;
      div_req.start = req_acc;
      div_req.dividend = c_in[PIX_W-1:0];
      div_req.divisor = d_in[PIX_W-1:0];
   end

   // Normalization and differences.
   always_comb begin
      lit_in = (d_ff >= LIT_MIN);
      if (!lit_in || c_ff <= 9'sd0) begin
         norm_in = '0;
      end else if (c_ff >= d_ff) begin
         norm_in = ONE_Q15;
      end else begin
         norm_in = {1'b0, div_rsp.quotient};
      end
      vdiff_in = '0;
      if (!first_row_ff && lit_in && up_entry[ENTRY_W-1]) begin
         vdiff_in = (norm_in > up_entry[NORM_W-1:0]) ? norm_in - up_entry[NORM_W-1:0]
                                                      : up_entry[NORM_W-1:0] - norm_in;
      end
      hdiff_in = '0;
      if (horiz_en_ff && col_ff != '0 && lit_in && left_ff[ENTRY_W-1]) begin
         hdiff_in = (norm_in > left_ff[NORM_W-1:0]) ? norm_in - left_ff[NORM_W-1:0]
                                                     : left_ff[NORM_W-1:0] - norm_in;
      end
   end

   // Marking and column advance.
   always_comb begin
      if (horiz_en_ff && hdiff_ff > thresh_ff) begin
         mark_in = MARK_HORIZ;
      end else if (vdiff_ff > thresh_ff) begin
         mark_in = MARK_VERT;
      end else begin
         mark_in = MARK_NONE;
      end
      row_width_ext = CMP_W'(row_width_ff);
      if (row_width_ext == '0) begin
         eff_width = CMP_W'(1);
      end else if (row_width_ext > MAX_W) begin
         eff_width = MAX_W;
      end else begin
         eff_width = row_width_ext;
      end
      col_next = CMP_W'(col_ff) + CMP_W'(1);
      col_in = col_ff;
      first_row_in = first_row_ff;
      if (req_acc && req_tuser) begin
         col_in = '0;
         first_row_in = 1'b1;
      end else if (emit_load) begin
         if (col_next >= eff_width) begin
            col_in = '0;
            first_row_in = 1'b0;
         end else begin
            col_in = col_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RST;
         thresh_ff <= THRESH_RST;
         horiz_en_ff <= 1'b0;
         col_ff <= '0;
         first_row_ff <= 1'b1;
         left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_WIDTH: row_width_ff <= csr_data[ROW_WIDTH_W-1:0];
               CSR_SHARP_THRESH: thresh_ff <= csr_data[THRESH_W-1:0];
               CSR_HORIZ_EN: horiz_en_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
         col_ff <= col_in;
         first_row_ff <= first_row_in;
         if (emit_load) begin
            left_ff <= {lit_ff, norm_ff};
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         d_ff <= d_in;
         c_ff <= c_in;
      end
      if (eval_load) begin
         lit_ff <= lit_in;
         norm_ff <= norm_in;
         vdiff_ff <= vdiff_in;
         hdiff_ff <= hdiff_in;
      end
      if (emit_load) begin
         out_norm_ff <= norm_ff;
         out_lit_ff <= lit_ff;
         out_vdiff_ff <= vdiff_ff;
         out_hdiff_ff <= hdiff_ff;
         out_mark_ff <= mark_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'b0, out_mark_ff, out_hdiff_ff, out_vdiff_ff, out_lit_ff, out_norm_ff};

   a_idle_div_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_rsp.busy)
      else $error("divider busy while sequencer is idle");

   a_unlit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_lit_ff) |-> (out_norm_ff == '0 && out_vdiff_ff == '0
                                         && out_hdiff_ff == '0 && out_mark_ff == MARK_NONE))
      else $error("unlit result carries nonzero fields");

   a_mark_has_diff: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_mark_ff == MARK_VERT) |-> (out_vdiff_ff != '0))
      else $error("vertical mark without vertical difference");

   a_eval_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> $past(state_ff == S_DIV))
      else $error("evaluation entered without a finished division");

endmodule
